/* hdl/static_arithmetic_encoder_macros.svh */
// ----------------------------------------------------------------------------
// static arithmetic encoder assertion macros
// concurrent checks clocked on i_clk and held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef STATIC_ARITHMETIC_ENCODER_MACROS_SVH
`define STATIC_ARITHMETIC_ENCODER_MACROS_SVH

// same-cycle implication
`define SAE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sae_pkg.sv */
// ----------------------------------------------------------------------------
// sae_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package sae_pkg;

    // model sizes
    localparam int SYMBOLS    = 256;
    localparam int PREC       = 32;
    localparam int COUNT_BITS = 24;

    // derived widths
    localparam int SYM_W      = 8;
    localparam int SYM_AW     = $clog2(SYMBOLS);
    localparam int ADDR_W     = $clog2(SYMBOLS + 1);
    localparam int CUM_W      = COUNT_BITS + 1;
    localparam int ACC_W      = COUNT_BITS + SYM_AW;
    localparam int PROD_W     = PREC + CUM_W;
    localparam int REM_W      = CUM_W + 1;
    localparam int QUO_W      = PREC + 1;
    localparam int DIV_CNT_W  = $clog2(PROD_W);
    localparam int ITER_W     = $clog2(PREC + 1);

    // interval constants
    localparam logic [PREC-1:0] HALF    = PREC'(1) << (PREC - 1);
    localparam logic [PREC-1:0] QUARTER = PREC'(1) << (PREC - 2);
    localparam logic [PREC-1:0] THREEQ  = QUARTER + HALF;

    // largest usable model total
    localparam logic [ACC_W-1:0] TOTAL_LIMIT = (COUNT_BITS < PREC - 2) ?
        (ACC_W'(1) << COUNT_BITS) : (ACC_W'(1) << (PREC - 2));

    // input operations
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_PREP = 2'd1,
        OP_ENC  = 2'd2,
        OP_FIN  = 2'd3
    } t_op;

    // result kinds
    typedef enum logic [1:0] {
        K_BIT    = 2'd0,
        K_READY  = 2'd1,
        K_BAD    = 2'd2,
        K_ABSENT = 2'd3
    } t_kind;

    // controller to datapath commands
    typedef struct packed {
        logic              cap;
        logic              load_wr;
        logic              prep_clr;
        logic              prep_rd;
        logic              prep_acc;
        logic [ADDR_W-1:0] idx;
        logic              prep_fin;
        logic              enc_rd0;
        logic              enc_rd1;
        logic              enc_cap1;
        logic              mul;
        logic              mul_c1;
        logic              q1_cap;
        logic              div_load;
        logic              div_step;
        logic              upd;
        logic              rn_step;
        logic              rn_flush;
        logic              fin;
        logic              rej;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
        logic model_ok;
        logic sym_ok;
        logic absent;
        logic rn_emit;
        logic rn_stop;
        logic hold_vld;
    } t_sts;

endpackage

`default_nettype wire

/* hdl/sae_ram.sv */
// ----------------------------------------------------------------------------
// sae_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module sae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/sae_dp.sv */
// ----------------------------------------------------------------------------
// sae_dp
// encoder datapath: count and cumulative tables, interval, divider, output
// ----------------------------------------------------------------------------
`default_nettype none

module sae_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire sae_pkg::t_cmd                  i_cmd,
    output sae_pkg::t_sts                       o_sts,
    input  wire logic [sae_pkg::SYM_W-1:0]      i_sym,
    input  wire logic [sae_pkg::COUNT_BITS-1:0] i_count,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output sae_pkg::t_kind                      o_kind,
    output logic                                o_bit,
    output logic      [31:0]                    o_follow,
    output logic                                o_last
);

    // count table
    logic                              r_cnt_vld [sae_pkg::SYMBOLS];
    logic                              r_cvld_q;
    logic [sae_pkg::COUNT_BITS-1:0]    cnt_rdata;
    logic                              cnt_wr;

    // cumulative table and model
    logic [sae_pkg::CUM_W-1:0]         cum_rdata;
    logic [sae_pkg::ADDR_W-1:0]        cum_raddr;
    logic [sae_pkg::ACC_W-1:0]         r_acc;
    logic [sae_pkg::ACC_W-1:0]         n_acc;
    logic [sae_pkg::CUM_W-1:0]         r_total;
    logic                              total_ok;
    logic [sae_pkg::SYM_W-1:0]         r_sym;
    logic [sae_pkg::CUM_W-1:0]         r_c0;
    logic [sae_pkg::CUM_W-1:0]         r_c1;
    logic [sae_pkg::CUM_W-1:0]         r_cm;

    // interval
    logic [sae_pkg::PREC-1:0]          r_low;
    logic [sae_pkg::PREC-1:0]          r_high;
    logic [31:0]                       r_pend;
    logic [31:0]                       pend_inc;

    // multiplier and divider
    logic [sae_pkg::PREC-1:0]          span_m1;
    logic [sae_pkg::PROD_W-1:0]        r_mul;
    logic [sae_pkg::PROD_W-1:0]        r_dvd;
    logic [sae_pkg::CUM_W-1:0]         r_rem;
    logic [sae_pkg::REM_W-1:0]         rem_sh;
    logic                              q_ge;
    logic [sae_pkg::QUO_W-1:0]         r_q1;
    logic [sae_pkg::PREC+1:0]          hi_sum;
    logic [sae_pkg::PREC+1:0]          lo_sum;

    // renormalisation
    logic                              e0;
    logic                              e1;
    logic                              pd;
    logic [sae_pkg::PREC-1:0]          lo_t;
    logic [sae_pkg::PREC-1:0]          hi_t;
    logic                              r_hold_vld;
    logic                              r_hold_bit;
    logic [31:0]                       r_hold_fc;

    // output register
    logic                              r_out_vld;
    sae_pkg::t_kind                    r_kind;
    logic                              r_bit;
    logic [31:0]                       r_fc;
    logic                              r_last;

    assign cnt_wr = i_cmd.load_wr && ({1'b0, i_sym} < (sae_pkg::SYM_W + 1)'(sae_pkg::SYMBOLS));

    sae_ram #(
        .WIDTH (sae_pkg::COUNT_BITS),
        .DEPTH (sae_pkg::SYMBOLS)
    ) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cnt_wr),
        .i_wr_addr (i_sym[sae_pkg::SYM_AW-1:0]),
        .i_wr_data (i_count),
        .i_rd_en   (i_cmd.prep_rd),
        .i_rd_addr (i_cmd.idx[sae_pkg::SYM_AW-1:0]),
        .o_rd_data (cnt_rdata)
    );

    // running sum during the prepare sweep
    always_comb begin
        n_acc = r_acc + (r_cvld_q ? sae_pkg::ACC_W'(cnt_rdata) : '0);
    end

    assign cum_raddr = i_cmd.enc_rd1 ? (sae_pkg::ADDR_W'(r_sym) + sae_pkg::ADDR_W'(1))
                                     : sae_pkg::ADDR_W'(r_sym);

    sae_ram #(
        .WIDTH (sae_pkg::CUM_W),
        .DEPTH (sae_pkg::SYMBOLS + 1)
    ) u_cum_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.prep_acc),
        .i_wr_addr (i_cmd.idx),
        .i_wr_data (n_acc[sae_pkg::CUM_W-1:0]),
        .i_rd_en   (i_cmd.enc_rd0 || i_cmd.enc_rd1),
        .i_rd_addr (cum_raddr),
        .o_rd_data (cum_rdata)
    );

    assign total_ok = (r_acc != '0) && (r_acc <= sae_pkg::TOTAL_LIMIT);
    assign pend_inc = (r_pend == '1) ? r_pend : r_pend + 32'd1;
    assign span_m1  = r_high - r_low;

    // long division step
    assign rem_sh = {r_rem, r_dvd[sae_pkg::PROD_W-1]};
    assign q_ge   = rem_sh >= sae_pkg::REM_W'(r_total);

    // interval update from the two quotients
    assign hi_sum = (sae_pkg::PREC + 2)'(r_low) + (sae_pkg::PREC + 2)'(r_q1)
                  - (sae_pkg::PREC + 2)'(1);
    assign lo_sum = (sae_pkg::PREC + 2)'(r_low) + (sae_pkg::PREC + 2)'(r_dvd[sae_pkg::QUO_W-1:0]);

    // renormalisation decision
    always_comb begin
        e0   = r_high < sae_pkg::HALF;
        e1   = !e0 && (r_low >= sae_pkg::HALF);
        pd   = !e0 && !e1 && (r_low >= sae_pkg::QUARTER) && (r_high < sae_pkg::THREEQ);
        lo_t = r_low;
        hi_t = r_high;
        if (e1) begin
            lo_t = r_low - sae_pkg::HALF;
            hi_t = r_high - sae_pkg::HALF;
        end else if (pd) begin
            lo_t = r_low - sae_pkg::QUARTER;
            hi_t = r_high - sae_pkg::QUARTER;
        end
    end

    // count valid bits and prepare sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sae_pkg::SYMBOLS; i++) begin
                r_cnt_vld[i] <= 1'b0;
            end
        end else if (cnt_wr) begin
            r_cnt_vld[i_sym[sae_pkg::SYM_AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep_rd) begin
            r_cvld_q <= r_cnt_vld[i_cmd.idx[sae_pkg::SYM_AW-1:0]];
        end
        if (i_cmd.prep_clr) begin
            r_acc <= '0;
        end else if (i_cmd.prep_acc) begin
            r_acc <= n_acc;
        end
        if (i_cmd.cap) begin
            r_sym <= i_sym;
        end
        if (i_cmd.enc_rd1) begin
            r_c0 <= (r_sym == '0) ? '0 : cum_rdata;
        end
        if (i_cmd.enc_cap1) begin
            r_c1 <= cum_rdata;
        end
    end

    // multiplier and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_mul <= sae_pkg::PROD_W'(span_m1 * (i_cmd.mul_c1 ? r_c1 : r_c0));
            r_cm  <= i_cmd.mul_c1 ? r_c1 : r_c0;
        end
        if (i_cmd.q1_cap) begin
            r_q1 <= r_dvd[sae_pkg::QUO_W-1:0];
        end
        if (i_cmd.div_load) begin
            r_dvd <= r_mul + sae_pkg::PROD_W'(r_cm);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[sae_pkg::PROD_W-2:0], q_ge};
            r_rem <= q_ge ? sae_pkg::CUM_W'(rem_sh - sae_pkg::REM_W'(r_total))
                          : sae_pkg::CUM_W'(rem_sh);
        end
    end

    // model total, interval and pending bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= '0;
            r_low      <= '0;
            r_high     <= '1;
            r_pend     <= '0;
            r_hold_vld <= 1'b0;
        end else begin
            if (i_cmd.prep_fin) begin
                r_total <= total_ok ? r_acc[sae_pkg::CUM_W-1:0] : '0;
                r_low   <= '0;
                r_high  <= '1;
                r_pend  <= '0;
            end
            if (i_cmd.upd) begin
                r_high <= hi_sum[sae_pkg::PREC-1:0];
                r_low  <= lo_sum[sae_pkg::PREC-1:0];
            end
            if (i_cmd.rn_step) begin
                r_low  <= {lo_t[sae_pkg::PREC-2:0], 1'b0};
                r_high <= {hi_t[sae_pkg::PREC-2:0], 1'b1};
                if (e0 || e1) begin
                    r_pend     <= '0;
                    r_hold_vld <= 1'b1;
                    r_hold_bit <= e1;
                    r_hold_fc  <= r_pend;
                end else if (pd) begin
                    r_pend <= pend_inc;
                end
            end
            if (i_cmd.rn_flush) begin
                r_hold_vld <= 1'b0;
            end
            if (i_cmd.fin) begin
                r_pend <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.prep_fin) begin
                r_out_vld <= 1'b1;
                r_kind    <= total_ok ? sae_pkg::K_READY : sae_pkg::K_BAD;
                r_bit     <= 1'b0;
                r_fc      <= '0;
                r_last    <= 1'b1;
            end else if (i_cmd.rej) begin
                r_out_vld <= 1'b1;
                r_kind    <= sae_pkg::K_ABSENT;
                r_bit     <= 1'b0;
                r_fc      <= '0;
                r_last    <= 1'b1;
            end else if (i_cmd.fin) begin
                r_out_vld <= 1'b1;
                r_kind    <= sae_pkg::K_BIT;
                r_bit     <= r_low >= sae_pkg::QUARTER;
                r_fc      <= pend_inc;
                r_last    <= 1'b1;
            end else if (i_cmd.rn_flush || (i_cmd.rn_step && (e0 || e1) && r_hold_vld)) begin
                r_out_vld <= 1'b1;
                r_kind    <= sae_pkg::K_BIT;
                r_bit     <= r_hold_bit;
                r_fc      <= r_hold_fc;
                r_last    <= i_cmd.rn_flush;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid  = r_out_vld;
    assign o_kind   = r_kind;
    assign o_bit    = r_bit;
    assign o_follow = r_fc;
    assign o_last   = r_last;

    // status
    always_comb begin
        o_sts.out_free = !r_out_vld || i_ready;
        o_sts.model_ok = r_total != '0;
        o_sts.sym_ok   = {1'b0, i_sym} < (sae_pkg::SYM_W + 1)'(sae_pkg::SYMBOLS);
        o_sts.absent   = cum_rdata <= r_c0;
        o_sts.rn_emit  = e0 || e1;
        o_sts.rn_stop  = !(e0 || e1 || pd);
        o_sts.hold_vld = r_hold_vld;
    end

endmodule

`default_nettype wire

/* hdl/sae_ctrl.sv */
// ----------------------------------------------------------------------------
// sae_ctrl
// encoder sequencer: prepare sweep, slice division, renormalisation loop
// ----------------------------------------------------------------------------
`default_nettype none

module sae_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire sae_pkg::t_op  i_op,
    output logic               o_ready,
    input  wire sae_pkg::t_sts i_sts,
    output sae_pkg::t_cmd      o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_PREP  = 14'b00000000000010,
        S_PFIN  = 14'b00000000000100,
        S_RD0   = 14'b00000000001000,
        S_RD1   = 14'b00000000010000,
        S_CHK   = 14'b00000000100000,
        S_MUL   = 14'b00000001000000,
        S_DLD   = 14'b00000010000000,
        S_DIV   = 14'b00000100000000,
        S_UPD   = 14'b00001000000000,
        S_RN    = 14'b00010000000000,
        S_RNEND = 14'b00100000000000,
        S_FIN   = 14'b01000000000000,
        S_REJ   = 14'b10000000000000
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    logic [sae_pkg::ADDR_W-1:0]      r_idx;
    logic [sae_pkg::ADDR_W-1:0]      n_idx;
    logic [sae_pkg::DIV_CNT_W-1:0]   r_div;
    logic [sae_pkg::DIV_CNT_W-1:0]   n_div;
    logic [sae_pkg::ITER_W-1:0]      r_iter;
    logic [sae_pkg::ITER_W-1:0]      n_iter;
    logic                            r_pass;
    logic                            n_pass;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_div   = r_div;
        n_iter  = r_iter;
        n_pass  = r_pass;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    unique case (i_op)
                        sae_pkg::OP_LOAD: o_cmd.load_wr = 1'b1;
                        sae_pkg::OP_PREP: begin
                            o_cmd.prep_clr = 1'b1;
                            n_idx          = '0;
                            n_state        = S_PREP;
                        end
                        sae_pkg::OP_ENC: begin
                            n_state = (i_sts.model_ok && i_sts.sym_ok) ? S_RD0 : S_REJ;
                        end
                        sae_pkg::OP_FIN: n_state = S_FIN;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_PREP: begin
                o_cmd.idx      = r_idx;
                o_cmd.prep_rd  = r_idx < sae_pkg::ADDR_W'(sae_pkg::SYMBOLS);
                o_cmd.prep_acc = r_idx != '0;
                if (r_idx == sae_pkg::ADDR_W'(sae_pkg::SYMBOLS)) begin
                    n_state = S_PFIN;
                end else begin
                    n_idx = r_idx + sae_pkg::ADDR_W'(1);
                end
            end
            S_PFIN: begin
                if (i_sts.out_free) begin
                    o_cmd.prep_fin = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_RD0: begin
                o_cmd.enc_rd0 = 1'b1;
                n_state       = S_RD1;
            end
            S_RD1: begin
                o_cmd.enc_rd1 = 1'b1;
                n_state       = S_CHK;
            end
            S_CHK: begin
                o_cmd.enc_cap1 = 1'b1;
                n_pass         = 1'b1;
                n_state        = i_sts.absent ? S_REJ : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul    = 1'b1;
                o_cmd.mul_c1 = r_pass;
                o_cmd.q1_cap = !r_pass;
                n_state      = S_DLD;
            end
            S_DLD: begin
                o_cmd.div_load = 1'b1;
                n_div          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_div == sae_pkg::DIV_CNT_W'(sae_pkg::PROD_W - 1)) begin
                    n_pass  = 1'b0;
                    n_state = r_pass ? S_MUL : S_UPD;
                end else begin
                    n_div = r_div + sae_pkg::DIV_CNT_W'(1);
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_iter    = '0;
                n_state   = S_RN;
            end
            S_RN: begin
                if ((r_iter == sae_pkg::ITER_W'(sae_pkg::PREC)) || i_sts.rn_stop) begin
                    n_state = S_RNEND;
                end else if (!(i_sts.rn_emit && i_sts.hold_vld && !i_sts.out_free)) begin
                    o_cmd.rn_step = 1'b1;
                    n_iter        = r_iter + sae_pkg::ITER_W'(1);
                end
            end
            S_RNEND: begin
                if (!i_sts.hold_vld) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.rn_flush = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_REJ: begin
                if (i_sts.out_free) begin
                    o_cmd.rej = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_div   <= '0;
            r_iter  <= '0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_div   <= n_div;
            r_iter  <= n_iter;
            r_pass  <= n_pass;
        end
    end

endmodule

`default_nettype wire

/* hdl/static_arithmetic_encoder.sv */
// ----------------------------------------------------------------------------
// static_arithmetic_encoder
// order-0 static-model arithmetic encoder, 32-bit interval, pending bits
// ----------------------------------------------------------------------------
// usage
//   slave channel: tuser carries the operation (load, prepare, encode,
//   finish), tdata carries symbol and count. one item is taken at a time.
//   master channel: tuser carries the result kind, tdata the code bit and
//   its follow count, tlast marks the final result of an input item.
//   load writes one count. prepare sweeps the count table, then waits
//   for a free output. encode reads the cumulative table, runs two
//   bit-serial divisions on the shared one-bit-per-cycle divider and one
//   interval update, then renormalises one bit per cycle unless a decided
//   bit waits on a busy output.
//   finish and encodes rejected for want of a model go straight to the
//   output; a symbol with no count is rejected after the table reads.
//   reset clears the counts (valid bits), the model and the interval.
//   a stalled receiver holds the output register and the renormaliser
//   waits on it; tready on the slave side stays low until the item is done.
// ----------------------------------------------------------------------------
`default_nettype none
`include "static_arithmetic_encoder_macros.svh"

module static_arithmetic_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // symbol[7:0], count[31:8]
    input  wire logic [1:0]  i_s_tuser,   // opcode[1:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [39:0] o_m_tdata,   // out_bit[0], follow_count[32:1], zero pad
    output logic      [1:0]  o_m_tuser,   // kind[1:0]
    output logic             o_m_tlast    // last
);

    sae_pkg::t_cmd  cmd;
    sae_pkg::t_sts  sts;
    sae_pkg::t_kind kind;
    logic           out_bit;
    logic [31:0]    follow;

    sae_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_op    (sae_pkg::t_op'(i_s_tuser)),
        .o_ready (o_s_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sae_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_sym    (i_s_tdata[7:0]),
        .i_count  (i_s_tdata[31:8]),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_kind   (kind),
        .o_bit    (out_bit),
        .o_follow (follow),
        .o_last   (o_m_tlast)
    );

    assign o_m_tdata = {7'd0, follow, out_bit};
    assign o_m_tuser = kind;

    // single results only go out into a free output register
    `SAE_ASSERT_IMP(a_single_free, cmd.prep_fin || cmd.fin || cmd.rej || cmd.rn_flush, sts.out_free, "result pushed into busy output")
    // renormaliser hands on a held bit only when the output can take it
    `SAE_ASSERT_IMP(a_hold_free, cmd.rn_step && sts.rn_emit && sts.hold_vld, sts.out_free, "held bit pushed into busy output")
    // a renormalisation step is never taken once the interval is settled
    `SAE_ASSERT_IMP(a_rn_live, cmd.rn_step, !sts.rn_stop, "renormalisation step past its end")
    // the model stays usable until the next prepare
    `SAE_ASSERT_NXT(a_model_keep, !cmd.prep_fin && sts.model_ok, sts.model_ok, "model lost without prepare")

endmodule

`default_nettype wire

/* tb/sv/static_arithmetic_encoder_tb.sv */
// ----------------------------------------------------------------------------
// static_arithmetic_encoder_tb
// self-checking bench: directed table then random load/prepare/encode/finish
// runs, every result compared with a bit-exact interval coder predictor
// ----------------------------------------------------------------------------
`default_nettype none

module static_arithmetic_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned MASK32  = 64'hFFFF_FFFF;
    localparam longint unsigned IV_HALF = 64'h8000_0000;
    localparam longint unsigned IV_QTR  = 64'h4000_0000;
    localparam longint unsigned IV_3Q   = 64'hC000_0000;
    localparam longint unsigned LIMIT   = 64'h100_0000;
    localparam int              STALL_LIMIT = 20000;
    localparam int              HOLD_CYCLES = 400;

    typedef struct packed {
        sae_pkg::t_kind kind;
        logic  code_bit;
        logic [31:0] follow;
        logic  last;
    } t_code_res;

    typedef struct packed {
        sae_pkg::t_op   op;
        logic [7:0]     sym;
        logic [23:0]    cnt;
        logic           typed;
        sae_pkg::t_kind kind;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;   // symbol[7:0], count[31:8]
    logic [1:0]  i_s_tuser;   // opcode[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;   // out_bit[0], follow_count[32:1], zero pad
    logic [1:0]  o_m_tuser;   // kind[1:0]
    logic        o_m_tlast;

    static_arithmetic_encoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // coder state mirror
    logic [23:0]     cnt_tab [sae_pkg::SYMBOLS];
    longint unsigned cum_tab [sae_pkg::SYMBOLS+1];
    longint unsigned iv_low, iv_high, pend_bits, mdl_total;

    t_code_res code_q [$];
    int  idle_pct;
    int  stall_pct;
    bit  hold_req;
    bit  failed;
    int  quiet_cycles;
    int  n_items;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // queue one decided bit with its pending run
    task automatic push_bit(input logic b);
        code_q.push_back('{sae_pkg::K_BIT, b, pend_bits[31:0], 1'b0});
        pend_bits = 0;
    endtask

    task automatic bump_pend();
        if (pend_bits < MASK32) pend_bits++;
    endtask

    // work out the results of one accepted item
    task automatic code_step(input sae_pkg::t_op op, input logic [7:0] sym,
                             input logic [23:0] cnt);
        longint unsigned acc, c0, c1, span;
        int n0;
        n0 = code_q.size();
        case (op)
            sae_pkg::OP_LOAD: begin
                cnt_tab[sym] = cnt;
            end
            sae_pkg::OP_PREP: begin
                acc = 0;
                cum_tab[0] = 0;
                for (int i = 0; i < sae_pkg::SYMBOLS; i++) begin
                    acc += cnt_tab[i];
                    cum_tab[i+1] = acc & 64'h1FF_FFFF;
                end
                iv_low = 0; iv_high = MASK32; pend_bits = 0;
                if (acc == 0 || acc > LIMIT) begin
                    mdl_total = 0;
                    code_q.push_back('{sae_pkg::K_BAD, 1'b0, 32'd0, 1'b0});
                end else begin
                    mdl_total = acc;
                    code_q.push_back('{sae_pkg::K_READY, 1'b0, 32'd0, 1'b0});
                end
            end
            sae_pkg::OP_ENC: begin
                if (mdl_total == 0 || cum_tab[sym+1] <= cum_tab[sym]) begin
                    code_q.push_back('{sae_pkg::K_ABSENT, 1'b0, 32'd0, 1'b0});
                end else begin
                    c0 = cum_tab[sym];
                    c1 = cum_tab[sym+1];
                    span = ((iv_high - iv_low) & MASK32) + 1;
                    iv_high = (iv_low + (span * c1) / mdl_total - 1) & MASK32;
                    iv_low  = (iv_low + (span * c0) / mdl_total) & MASK32;
                    // renormalise, at most one step per interval bit
                    for (int it = 0; it < 32; it++) begin
                        if (iv_high < IV_HALF) begin
                            push_bit(1'b0);
                        end else if (iv_low >= IV_HALF) begin
                            push_bit(1'b1);
                            iv_low -= IV_HALF;
                            iv_high -= IV_HALF;
                        end else if (iv_low >= IV_QTR && iv_high < IV_3Q) begin
                            bump_pend();
                            iv_low -= IV_QTR;
                            iv_high -= IV_QTR;
                        end else begin
                            break;
                        end
                        iv_low  = (iv_low << 1) & MASK32;
                        iv_high = ((iv_high << 1) | 1) & MASK32;
                    end
                end
            end
            default: begin
                bump_pend();
                push_bit((iv_low < IV_QTR) ? 1'b0 : 1'b1);
            end
        endcase
        if (code_q.size() > n0) code_q[$].last = 1'b1;
    endtask

    // offer one item, idling first at random; returns at the falling edge
    task automatic send_item(input sae_pkg::t_op op, input logic [7:0] sym,
                             input logic [23:0] cnt, input logic typed = 1'b0,
                             input sae_pkg::t_kind kind = sae_pkg::K_BIT);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {cnt, sym};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        code_step(op, sym, cnt);
        n_items++;
        // hand-typed kind for rows whose answer is plain
        if (typed) code_q[$].kind = kind;
        @(negedge i_clk);
    endtask

    // withdraw the offer and wait for every expected result
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (code_q.size() != 0) @(negedge i_clk);
    endtask

    // receiver: random stalls, or one long hold-off on request
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_code_res want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (code_q.size() == 0) begin
                $error("result item with nothing expected: kind %0d", o_m_tuser);
                failed = 1'b1;
            end else begin
                want = code_q.pop_front();
                if (o_m_tuser !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_m_tuser);
                    failed = 1'b1;
                end
                if (o_m_tdata[0] !== want.code_bit) begin
                    $error("out_bit: expected %0d, got %0d", want.code_bit, o_m_tdata[0]);
                    failed = 1'b1;
                end
                if (o_m_tdata[32:1] !== want.follow) begin
                    $error("follow_count: expected %0d, got %0d", want.follow,
                           o_m_tdata[32:1]);
                    failed = 1'b1;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_m_tlast);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // directed rows: no model, bad totals, exact limit, zero counts
    t_row dir_rows [] = '{
        '{sae_pkg::OP_ENC,  8'd0,   24'd0,      1'b1, sae_pkg::K_ABSENT},
        '{sae_pkg::OP_FIN,  8'd0,   24'd0,      1'b0, sae_pkg::K_BIT},
        '{sae_pkg::OP_PREP, 8'd0,   24'd0,      1'b1, sae_pkg::K_BAD},
        '{sae_pkg::OP_LOAD, 8'd255, 24'hFFFFFF, 1'b0, sae_pkg::K_BIT},
        '{sae_pkg::OP_PREP, 8'd0,   24'd0,      1'b1, sae_pkg::K_READY},
        '{sae_pkg::OP_ENC,  8'd255, 24'd0,      1'b0, sae_pkg::K_BIT},
        '{sae_pkg::OP_ENC,  8'd0,   24'd0,      1'b1, sae_pkg::K_ABSENT},
        '{sae_pkg::OP_LOAD, 8'd0,   24'd1,      1'b0, sae_pkg::K_BIT},
        '{sae_pkg::OP_PREP, 8'd0,   24'd0,      1'b1, sae_pkg::K_READY},
        '{sae_pkg::OP_ENC,  8'd0,   24'd0,      1'b0, sae_pkg::K_BIT},
        '{sae_pkg::OP_ENC,  8'd255, 24'd0,      1'b0, sae_pkg::K_BIT},
        '{sae_pkg::OP_FIN,  8'd0,   24'd0,      1'b0, sae_pkg::K_BIT},
        '{sae_pkg::OP_LOAD, 8'd1,   24'd1,      1'b0, sae_pkg::K_BIT},
        '{sae_pkg::OP_PREP, 8'd0,   24'd0,      1'b1, sae_pkg::K_BAD},
        '{sae_pkg::OP_ENC,  8'd1,   24'd0,      1'b1, sae_pkg::K_ABSENT},
        '{sae_pkg::OP_LOAD, 8'd255, 24'd0,      1'b0, sae_pkg::K_BIT},
        '{sae_pkg::OP_PREP, 8'd0,   24'd0,      1'b1, sae_pkg::K_READY},
        '{sae_pkg::OP_ENC,  8'd1,   24'd0,      1'b0, sae_pkg::K_BIT},
        '{sae_pkg::OP_ENC,  8'd0,   24'd0,      1'b0, sae_pkg::K_BIT},
        '{sae_pkg::OP_LOAD, 8'd0,   24'd5,      1'b0, sae_pkg::K_BIT},
        '{sae_pkg::OP_ENC,  8'd0,   24'd0,      1'b0, sae_pkg::K_BIT},
        '{sae_pkg::OP_ENC,  8'd1,   24'd0,      1'b0, sae_pkg::K_BIT},
        '{sae_pkg::OP_FIN,  8'd0,   24'd0,      1'b0, sae_pkg::K_BIT},
        '{sae_pkg::OP_LOAD, 8'd0,   24'd0,      1'b0, sae_pkg::K_BIT},
        '{sae_pkg::OP_LOAD, 8'd1,   24'd0,      1'b0, sae_pkg::K_BIT}
    };

    // main sequence
    initial begin
        logic [7:0] used_syms [$];
        int n_used, n_enc, scale, seq;
        logic [23:0] c;

        failed     = 1'b0;
        hold_req   = 1'b0;
        idle_pct   = 0;
        stall_pct  = 0;
        n_items    = 0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        for (int i = 0; i < sae_pkg::SYMBOLS; i++) cnt_tab[i] = '0;
        for (int i = 0; i <= sae_pkg::SYMBOLS; i++) cum_tab[i] = 0;
        iv_low = 0; iv_high = MASK32; pend_bits = 0; mdl_total = 0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r])
            send_item(dir_rows[r].op, dir_rows[r].sym, dir_rows[r].cnt,
                      dir_rows[r].typed, dir_rows[r].kind);

        // random runs: clear, load a small alphabet, prepare, encode, finish
        seq = 0;
        while (n_items < 250) begin
            drain_results();
            case (seq % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 49; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 49; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            for (int i = 0; i < sae_pkg::SYMBOLS; i++)
                if (cnt_tab[i] != 0) send_item(sae_pkg::OP_LOAD, 8'(i), 24'd0);
            used_syms.delete();
            n_used = $urandom_range(2, 6);
            scale  = $urandom_range(0, 3);
            for (int i = 0; i < n_used; i++) begin
                used_syms.push_back(8'($urandom_range(0, 255)));
                if (scale == 0 && i == 0)
                    c = 24'($urandom());
                else if ($urandom_range(0, 9) == 0)
                    c = 24'd0;
                else
                    c = 24'($urandom_range(1, 255));
                send_item(sae_pkg::OP_LOAD, used_syms[i], c);
            end
            send_item(sae_pkg::OP_PREP, 8'($urandom()), 24'($urandom()));
            // one long receiver hold-off while items keep coming
            if (seq == 0) hold_req = 1'b1;
            n_enc = $urandom_range(10, 30);
            for (int i = 0; i < n_enc; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(sae_pkg::t_op'($urandom_range(0, 3)), 8'($urandom()),
                              24'($urandom()));
                else if ($urandom_range(0, 99) < 85)
                    send_item(sae_pkg::OP_ENC, used_syms[$urandom_range(0, n_used - 1)],
                              24'($urandom()));
                else
                    send_item(sae_pkg::OP_ENC, 8'($urandom()), 24'($urandom()));
            end
            send_item(sae_pkg::OP_FIN, 8'($urandom()), 24'($urandom()));
            seq++;
        end

        drain_results();
        repeat (200) @(posedge i_clk);
        if (!failed && code_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
